// ===== design/mtel_pkg.sv =====
// mtel_pkg: shared constants, codes and types of the multi timer expiry list
// no dependencies; used by the interfaces, the top, mtel_ctrl and the bench
`timescale 1ns / 1ps
`default_nettype none

package mtel_pkg;

	localparam int CAPACITY  = 16;
	localparam int TIME_BITS = 24;
	localparam int TYPE_BITS = 8;

	// index into the timer memory, count of stored timers
	localparam int IDX_BITS = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_BITS = $clog2(CAPACITY + 1);

	// configuration register indexes
	localparam int CFG_IDX_BITS = 2;
	localparam logic [CFG_IDX_BITS-1:0] REG_MIN_DURATION = 2'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_TICK_STEP    = 2'd1;

	localparam logic [TIME_BITS-1:0] MIN_DURATION_RESET = TIME_BITS'(250);
	localparam logic [TIME_BITS-1:0] TICK_STEP_RESET    = TIME_BITS'(250);

	// input modes and result kinds
	localparam logic MODE_ADD    = 1'b0;
	localparam logic MODE_TICK   = 1'b1;
	localparam logic KIND_ACK    = 1'b0;
	localparam logic KIND_EXPIRY = 1'b1;

	// one stored timer
	typedef struct packed {
		logic [TIME_BITS-1:0] remaining;
		logic [TYPE_BITS-1:0] type_code;
	} entry_t;

	localparam int ENTRY_BITS = $bits(entry_t);

	// request from the sequencer to the timer memory
	typedef struct packed {
		logic                  we;
		logic [IDX_BITS-1:0]   waddr;
		entry_t                wdata;
		logic                  re;
		logic [IDX_BITS-1:0]   raddr;
	} ram_req_t;

endpackage

`default_nettype wire

// ===== design/mtel_if.sv =====
// mtel_if: valid/ready channels of the multi timer expiry list
// depends on mtel_pkg for field widths
`timescale 1ns / 1ps
`default_nettype none

// input items: add a timer or one tick
interface mtel_in_if;
	logic                           valid;
	logic                           ready;
	logic                           mode;
	logic [mtel_pkg::TIME_BITS-1:0] duration;
	logic [mtel_pkg::TYPE_BITS-1:0] new_type;

	modport source (output valid, mode, duration, new_type, input ready);
	modport sink (input valid, mode, duration, new_type, output ready);
endinterface

// result items: add acknowledgements and expiries
interface mtel_out_if;
	logic                           valid;
	logic                           ready;
	logic                           kind;
	logic                           accepted;
	logic [mtel_pkg::TYPE_BITS-1:0] expired_type;
	logic                           last;

	modport source (output valid, kind, accepted, expired_type, last, input ready);
	modport sink (input valid, kind, accepted, expired_type, last, output ready);
endinterface

// configuration register writes
interface mtel_cfg_if;
	logic                              valid;
	logic                              ready;
	logic [mtel_pkg::CFG_IDX_BITS-1:0] index;
	logic [mtel_pkg::TIME_BITS-1:0]    data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== design/multi_timer_expiry_list_top.sv =====
// Bank of 16 one-shot timers kept in insertion order. An add transaction
// (mode 0) yields one acknowledgement with last set. A tick transaction
// (mode 1) walks the stored timers through the timer memory, one entry per
// cycle unless the result side stalls the walk; a tick on an empty bank
// yields nothing. The walk rate is set by the single read port of the timer
// memory. Expiries come out in list order, the final one with last set.
// Configuration writes are taken at any time but must only be issued while
// the block is idle.
// depends on mtel_pkg, mtel_if, mtel_ram and mtel_ctrl
`timescale 1ns / 1ps
`default_nettype none

module multi_timer_expiry_list_top (
	input  wire logic  clk,
	input  wire logic  arst_n,
	mtel_in_if.sink    in_item,
	mtel_out_if.source out_item,
	mtel_cfg_if.sink   cfg
);

	mtel_pkg::ram_req_t               ram_req;
	logic [mtel_pkg::ENTRY_BITS-1:0]  ram_rdata;

	// sequencer
	mtel_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_item   (in_item),
		.out_item  (out_item),
		.cfg       (cfg),
		.ram_req   (ram_req),
		.ram_rdata (ram_rdata)
	);

	// timer memory: remaining time and type code per entry
	mtel_ram #(
		.ADDR_BITS (mtel_pkg::IDX_BITS),
		.DATA_BITS (mtel_pkg::ENTRY_BITS)
	) u_ram (
		.clk   (clk),
		.we    (ram_req.we),
		.waddr (ram_req.waddr),
		.wdata (ram_req.wdata),
		.re    (ram_req.re),
		.raddr (ram_req.raddr),
		.rdata (ram_rdata)
	);

endmodule

`default_nettype wire

// ===== design/mtel_ram.sv =====
// mtel_ram: generic single write port, single read port memory
// registered read data; no dependencies
`timescale 1ns / 1ps
`default_nettype none

module mtel_ram #(
	parameter int ADDR_BITS = 4,
	parameter int DATA_BITS = 32
) (
	input  wire logic                 clk,
	input  wire logic                 we,
	input  wire logic [ADDR_BITS-1:0] waddr,
	input  wire logic [DATA_BITS-1:0] wdata,
	input  wire logic                 re,
	input  wire logic [ADDR_BITS-1:0] raddr,
	output logic      [DATA_BITS-1:0] rdata
);

	logic [DATA_BITS-1:0] mem [2**ADDR_BITS];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// read port, data holds while no read is issued
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

// ===== design/mtel_ctrl.sv =====
// mtel_ctrl: sequencer of the timer list; adds, tick walk with compaction, results
// depends on mtel_pkg and mtel_if; drives the timer memory through mtel_pkg::ram_req_t
`timescale 1ns / 1ps
`default_nettype none

module mtel_ctrl (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	mtel_in_if.sink                             in_item,
	mtel_out_if.source                          out_item,
	mtel_cfg_if.sink                            cfg,
	output mtel_pkg::ram_req_t                  ram_req,
	input  wire logic [mtel_pkg::ENTRY_BITS-1:0] ram_rdata
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_WALK,
		ST_FLUSH
	} state_t;

	state_t                          state_q;
	logic [mtel_pkg::CNT_BITS-1:0]   count_q;
	logic [mtel_pkg::IDX_BITS-1:0]   idx_q;
	logic [mtel_pkg::IDX_BITS-1:0]   kept_q;
	logic                            pend_valid_q;
	logic [mtel_pkg::TYPE_BITS-1:0]  pend_type_q;
	logic [mtel_pkg::TIME_BITS-1:0]  min_duration_q;
	logic [mtel_pkg::TIME_BITS-1:0]  tick_step_q;
	logic                            out_valid_q;
	logic                            out_kind_q;
	logic                            out_accepted_q;
	logic [mtel_pkg::TYPE_BITS-1:0]  out_type_q;
	logic                            out_last_q;

	logic                            slot_free;
	logic                            in_acc;
	logic                            add_ok;
	logic                            add_store;
	logic                            tick_start;
	mtel_pkg::entry_t                rd_entry;
	logic                            expire;
	logic                            stall;
	logic                            step_go;
	logic                            last_entry;
	logic [mtel_pkg::CNT_BITS-1:0]   kept_next;
	logic                            out_load;

	// handshake and decode
	assign slot_free     = !out_valid_q || out_item.ready;
	assign in_item.ready = (state_q == ST_IDLE) && slot_free;
	assign in_acc        = in_item.valid && in_item.ready;
	assign cfg.ready     = 1'b1;

	assign add_ok     = (in_item.duration >= min_duration_q)
		&& (count_q < mtel_pkg::CNT_BITS'(mtel_pkg::CAPACITY));
	assign add_store  = in_acc && (in_item.mode == mtel_pkg::MODE_ADD) && add_ok;
	assign tick_start = in_acc && (in_item.mode == mtel_pkg::MODE_TICK) && (count_q != '0);

	// evaluation of the entry returned by the memory
	assign rd_entry   = mtel_pkg::entry_t'(ram_rdata);
	assign expire     = rd_entry.remaining <= tick_step_q;
	assign stall      = (state_q == ST_WALK) && expire && pend_valid_q && !slot_free;
	assign step_go    = (state_q == ST_WALK) && !stall;
	assign last_entry = (mtel_pkg::CNT_BITS'(idx_q) + mtel_pkg::CNT_BITS'(1)) == count_q;
	assign kept_next  = mtel_pkg::CNT_BITS'(kept_q) + mtel_pkg::CNT_BITS'(!expire);

	// a new result transaction enters the result register
	assign out_load = ((state_q == ST_IDLE) && in_acc && (in_item.mode == mtel_pkg::MODE_ADD))
		|| (step_go && expire && pend_valid_q)
		|| ((state_q == ST_FLUSH) && slot_free);

	// memory requests: survivors close up at the kept position
	always_comb begin
		ram_req.we    = add_store || (step_go && !expire);
		ram_req.re    = tick_start || (step_go && !last_entry);
		ram_req.raddr = (state_q == ST_IDLE) ? '0 : idx_q + mtel_pkg::IDX_BITS'(1);
		if (state_q == ST_WALK) begin
			ram_req.waddr           = kept_q;
			ram_req.wdata.remaining = rd_entry.remaining - tick_step_q;
			ram_req.wdata.type_code = rd_entry.type_code;
		end else begin
			ram_req.waddr           = count_q[mtel_pkg::IDX_BITS-1:0];
			ram_req.wdata.remaining = in_item.duration;
			ram_req.wdata.type_code = in_item.new_type;
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_duration_q <= mtel_pkg::MIN_DURATION_RESET;
			tick_step_q    <= mtel_pkg::TICK_STEP_RESET;
		end else if (cfg.valid && cfg.ready) begin
			unique case (cfg.index)
				mtel_pkg::REG_MIN_DURATION: min_duration_q <= cfg.data;
				mtel_pkg::REG_TICK_STEP:    tick_step_q    <= cfg.data;
				default: ;
			endcase
		end
	end

	// sequencer state and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			count_q        <= '0;
			idx_q          <= '0;
			kept_q         <= '0;
			pend_valid_q   <= 1'b0;
			pend_type_q    <= '0;
			out_valid_q    <= 1'b0;
			out_kind_q     <= mtel_pkg::KIND_ACK;
			out_accepted_q <= 1'b0;
			out_type_q     <= '0;
			out_last_q     <= 1'b0;
		end else begin
			// result register loads a new transaction or drains once taken
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_item.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc && (in_item.mode == mtel_pkg::MODE_ADD)) begin
						out_kind_q     <= mtel_pkg::KIND_ACK;
						out_accepted_q <= add_ok;
						out_type_q     <= '0;
						out_last_q     <= 1'b1;
						if (add_ok) begin
							count_q <= count_q + mtel_pkg::CNT_BITS'(1);
						end
					end else if (tick_start) begin
						state_q <= ST_WALK;
						idx_q   <= '0;
						kept_q  <= '0;
					end
				end
				ST_WALK: begin
					if (step_go) begin
						if (expire) begin
							// previous expiry is not the last one
							if (pend_valid_q) begin
								out_kind_q     <= mtel_pkg::KIND_EXPIRY;
								out_accepted_q <= 1'b0;
								out_type_q     <= pend_type_q;
								out_last_q     <= 1'b0;
							end
							pend_valid_q <= 1'b1;
							pend_type_q  <= rd_entry.type_code;
						end
						kept_q <= kept_next[mtel_pkg::IDX_BITS-1:0];
						if (last_entry) begin
							count_q <= kept_next;
							state_q <= (pend_valid_q || expire) ? ST_FLUSH : ST_IDLE;
						end else begin
							idx_q <= idx_q + mtel_pkg::IDX_BITS'(1);
						end
					end
				end
				ST_FLUSH: begin
					if (slot_free) begin
						out_kind_q     <= mtel_pkg::KIND_EXPIRY;
						out_accepted_q <= 1'b0;
						out_type_q     <= pend_type_q;
						out_last_q     <= 1'b1;
						pend_valid_q   <= 1'b0;
						state_q        <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_item.valid        = out_valid_q;
	assign out_item.kind         = out_kind_q;
	assign out_item.accepted     = out_accepted_q;
	assign out_item.expired_type = out_type_q;
	assign out_item.last         = out_last_q;

	// list never holds more than the bank size
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= mtel_pkg::CNT_BITS'(mtel_pkg::CAPACITY))
		else $error("timer count exceeds capacity");

	// no expiry left over between items
	a_idle_no_pending: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> !pend_valid_q)
		else $error("pending expiry while idle");

	// compaction writes never overtake the read position
	a_kept_behind: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WALK) |-> (kept_q <= idx_q))
		else $error("compaction write ahead of read index");

	// a stored add grows the list by one
	a_add_grows: assert property (@(posedge clk) disable iff (!arst_n)
		add_store |=> (count_q == $past(count_q) + mtel_pkg::CNT_BITS'(1)))
		else $error("accepted add did not grow the list");

	// a walk ends with a flush only when an expiry is held
	a_flush_pending: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FLUSH) |-> pend_valid_q)
		else $error("flush without pending expiry");

endmodule

`default_nettype wire

// ===== verif/multi_timer_expiry_list_top_test.sv =====
// multi_timer_expiry_list_top_test: self-checking bench for the timer expiry list
// predicts acks and expiries per input transaction and checks every result in order
// depends on mtel_pkg, mtel_if and multi_timer_expiry_list_top
`timescale 1ns / 1ps

module multi_timer_expiry_list_top_test;

	localparam logic [mtel_pkg::TIME_BITS-1:0] TIME_MAX = {mtel_pkg::TIME_BITS{1'b1}};
	localparam int SETTLE_CYCLES = 40;

	typedef struct {
		logic                           kind;
		logic                           accepted;
		logic [mtel_pkg::TYPE_BITS-1:0] expired_type;
		logic                           last;
	} timer_result_t;

	logic clk;
	logic arst_n;

	mtel_in_if  in_item ();
	mtel_out_if out_item ();
	mtel_cfg_if cfg ();

	multi_timer_expiry_list_top uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_item  (in_item),
		.out_item (out_item),
		.cfg      (cfg)
	);

	// shadow of the timer bank and its registers
	logic [mtel_pkg::TIME_BITS-1:0] shadow_remaining [mtel_pkg::CAPACITY];
	logic [mtel_pkg::TYPE_BITS-1:0] shadow_type [mtel_pkg::CAPACITY];
	int                             shadow_count = 0;
	logic [mtel_pkg::TIME_BITS-1:0] shadow_min_duration = mtel_pkg::MIN_DURATION_RESET;
	logic [mtel_pkg::TIME_BITS-1:0] shadow_tick_step = mtel_pkg::TICK_STEP_RESET;

	timer_result_t pending_results [$];
	int            fail_count = 0;
	int            rx_hold_cycles = 0;
	bit            quiet = 1'b0;

	// clock, 8 ns period
	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	// append one expected result at the tail of the queue
	function automatic void queue_result(timer_result_t res);
		pending_results.insert(pending_results.size(), res);
	endfunction

	// update the shadow bank for one accepted transaction, queue its results
	function automatic void predict_timer_results(logic mode,
			logic [mtel_pkg::TIME_BITS-1:0] dur, logic [mtel_pkg::TYPE_BITS-1:0] typ);
		timer_result_t res;
		bit            ok;
		int            kept;
		int            fired;
		kept = 0;
		fired = 0;
		if (mode == mtel_pkg::MODE_ADD) begin
			ok = (dur >= shadow_min_duration) && (shadow_count < mtel_pkg::CAPACITY);
			if (ok) begin
				shadow_remaining[shadow_count] = dur;
				shadow_type[shadow_count] = typ;
				shadow_count++;
			end
			res = '{kind: mtel_pkg::KIND_ACK, accepted: ok, expired_type: '0, last: 1'b1};
			queue_result(res);
		end else begin
			for (int i = 0; i < shadow_count; i++) begin
				if (shadow_remaining[i] <= shadow_tick_step) begin
					res = '{kind: mtel_pkg::KIND_EXPIRY, accepted: 1'b0,
						expired_type: shadow_type[i], last: 1'b0};
					queue_result(res);
					fired++;
				end else begin
					shadow_remaining[kept] = shadow_remaining[i] - shadow_tick_step;
					shadow_type[kept] = shadow_type[i];
					kept++;
				end
			end
			shadow_count = kept;
			if (fired > 0)
				pending_results[pending_results.size() - 1].last = 1'b1;
		end
	endfunction

	// offer one transaction, with an optional random gap before it
	task automatic send_item(logic mode, logic [mtel_pkg::TIME_BITS-1:0] dur,
			logic [mtel_pkg::TYPE_BITS-1:0] typ);
		if (!quiet && $urandom_range(0, 3) == 0) begin
			in_item.valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		in_item.valid    <= 1'b1;
		in_item.mode     <= mode;
		in_item.duration <= dur;
		in_item.new_type <= typ;
		do @(posedge clk); while (!in_item.ready);
		predict_timer_results(mode, dur, typ);
	endtask

	// stop offering and wait until the block has drained
	task automatic settle();
		in_item.valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// register write, only while the block is idle
	task automatic write_reg(logic [mtel_pkg::CFG_IDX_BITS-1:0] idx,
			logic [mtel_pkg::TIME_BITS-1:0] value);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data  <= value;
		do @(posedge clk); while (!cfg.ready);
		if (idx == mtel_pkg::REG_MIN_DURATION)
			shadow_min_duration = value;
		else if (idx == mtel_pkg::REG_TICK_STEP)
			shadow_tick_step = value;
		cfg.valid <= 1'b0;
		@(posedge clk);
	endtask

	// duration around the current step and minimum, with some full-range noise
	function automatic logic [mtel_pkg::TIME_BITS-1:0] pick_duration();
		longint unsigned d;
		case ($urandom_range(0, 9))
			0: begin
				d = $urandom() & 32'h00FF_FFFF;
			end
			1: begin
				d = (shadow_min_duration > 0) ? shadow_min_duration - 1 : 0;
			end
			default: begin
				d = longint'(shadow_tick_step) * $urandom_range(0, 4)
					+ $urandom_range(0, shadow_tick_step);
				if (d < shadow_min_duration)
					d = shadow_min_duration;
			end
		endcase
		if (d > TIME_MAX)
			d = TIME_MAX;
		return d[mtel_pkg::TIME_BITS-1:0];
	endfunction

	// reset values of both registers, short and extreme durations, ticks with and without expiry
	task automatic test_reset_settings();
		send_item(mtel_pkg::MODE_ADD, '0, 8'h01);
		send_item(mtel_pkg::MODE_ADD, 24'd249, 8'h02);
		send_item(mtel_pkg::MODE_ADD, 24'd250, 8'hA5);
		send_item(mtel_pkg::MODE_ADD, TIME_MAX, 8'hFF);
		send_item(mtel_pkg::MODE_ADD, 24'd251, 8'h00);
		send_item(mtel_pkg::MODE_TICK, '0, '0);
		send_item(mtel_pkg::MODE_TICK, TIME_MAX, 8'hFF);
		send_item(mtel_pkg::MODE_TICK, '0, '0);
		settle();
		write_reg(mtel_pkg::REG_TICK_STEP, TIME_MAX);
		send_item(mtel_pkg::MODE_TICK, '0, '0);
		send_item(mtel_pkg::MODE_TICK, '0, '0);
	endtask

	// zero minimum: a zero duration is stored and fires on the next tick
	task automatic test_zero_duration();
		settle();
		write_reg(mtel_pkg::REG_MIN_DURATION, '0);
		write_reg(mtel_pkg::REG_TICK_STEP, 24'd1);
		send_item(mtel_pkg::MODE_ADD, '0, 8'h11);
		send_item(mtel_pkg::MODE_ADD, 24'd1, 8'h22);
		send_item(mtel_pkg::MODE_ADD, 24'd2, 8'h33);
		send_item(mtel_pkg::MODE_TICK, '0, '0);
		send_item(mtel_pkg::MODE_TICK, '0, '0);
		send_item(mtel_pkg::MODE_TICK, '0, '0);
	endtask

	// result side held off while the bank fills up past capacity
	task automatic test_full_bank_backpressure();
		settle();
		write_reg(mtel_pkg::REG_MIN_DURATION, 24'd10);
		write_reg(mtel_pkg::REG_TICK_STEP, 24'd100);
		rx_hold_cycles = 300;
		for (int i = 0; i <= mtel_pkg::CAPACITY; i++)
			send_item(mtel_pkg::MODE_ADD, mtel_pkg::TIME_BITS'(10 + i * 20),
				mtel_pkg::TYPE_BITS'(8'h80 + i));
		send_item(mtel_pkg::MODE_ADD, 24'd5, 8'h7F);
		send_item(mtel_pkg::MODE_TICK, '0, '0);
		send_item(mtel_pkg::MODE_ADD, 24'd1000, 8'h55);
		send_item(mtel_pkg::MODE_TICK, '0, '0);
		settle();
		write_reg(mtel_pkg::REG_TICK_STEP, TIME_MAX);
		send_item(mtel_pkg::MODE_TICK, '0, '0);
		send_item(mtel_pkg::MODE_TICK, '0, '0);
	endtask

	// random adds and ticks over several register settings, last phase without idling
	task automatic test_random_traffic();
		logic [mtel_pkg::TIME_BITS-1:0] min_list [4];
		logic [mtel_pkg::TIME_BITS-1:0] step_list [4];
		min_list = '{'0, 24'd100, TIME_MAX,
			mtel_pkg::TIME_BITS'($urandom_range(0, 32'h00FF_FFFF))};
		step_list = '{24'd1, 24'd37, TIME_MAX,
			mtel_pkg::TIME_BITS'($urandom_range(1, 32'h00FF_FFFF))};
		for (int p = 0; p < 4; p++) begin
			settle();
			write_reg(mtel_pkg::REG_MIN_DURATION, min_list[p]);
			write_reg(mtel_pkg::REG_TICK_STEP, step_list[p]);
			quiet = (p == 3);
			for (int n = 0; n < 16; n++) begin
				if ($urandom_range(0, 9) < 6)
					send_item(mtel_pkg::MODE_ADD, pick_duration(),
						mtel_pkg::TYPE_BITS'($urandom_range(0, 255)));
				else
					send_item(mtel_pkg::MODE_TICK, mtel_pkg::TIME_BITS'($urandom()),
						mtel_pkg::TYPE_BITS'($urandom()));
			end
		end
	endtask

	// result side: random stall bursts, or a long hold-off on request
	initial begin
		out_item.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (rx_hold_cycles > 0) begin
				out_item.ready <= 1'b0;
				repeat (rx_hold_cycles) @(posedge clk);
				rx_hold_cycles = 0;
				out_item.ready <= 1'b1;
			end else if (!quiet && $urandom_range(0, 5) == 0) begin
				out_item.ready <= 1'b0;
				repeat ($urandom_range(1, 4)) @(posedge clk);
				out_item.ready <= 1'b1;
			end else begin
				out_item.ready <= 1'b1;
			end
		end
	end

	// compare each result transaction with the oldest prediction
	always @(posedge clk) begin
		timer_result_t want;
		if (arst_n && out_item.valid && out_item.ready) begin
			if (pending_results.size() == 0) begin
				$display("%0t: result expected none actual kind=%0b accepted=%0b type=%0h last=%0b",
					$time, out_item.kind, out_item.accepted, out_item.expired_type,
					out_item.last);
				fail_count++;
			end else begin
				want = pending_results.pop_front();
				if (out_item.kind !== want.kind) begin
					$display("%0t: kind expected %0b actual %0b", $time, want.kind,
						out_item.kind);
					fail_count++;
				end
				if (out_item.accepted !== want.accepted) begin
					$display("%0t: accepted expected %0b actual %0b", $time, want.accepted,
						out_item.accepted);
					fail_count++;
				end
				if (out_item.expired_type !== want.expired_type) begin
					$display("%0t: expired_type expected %0h actual %0h", $time,
						want.expired_type, out_item.expired_type);
					fail_count++;
				end
				if (out_item.last !== want.last) begin
					$display("%0t: last expected %0b actual %0b", $time, want.last,
						out_item.last);
					fail_count++;
				end
			end
		end
	end

	// run limit
	initial begin
		#2000000;
		$display("tb: failure");
		$finish;
	end

	// reset, then the tests in turn
	initial begin
		arst_n           <= 1'b0;
		in_item.valid    <= 1'b0;
		in_item.mode     <= mtel_pkg::MODE_ADD;
		in_item.duration <= '0;
		in_item.new_type <= '0;
		cfg.valid        <= 1'b0;
		cfg.index        <= mtel_pkg::REG_MIN_DURATION;
		cfg.data         <= '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_settings();
		test_zero_duration();
		test_full_bank_backpressure();
		test_random_traffic();
		settle();

		if (fail_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
